/* rtl/core/spectrum_bar_char_mapper_macros.svh */
// ----------------------------------------------------------------------------
// Spectrum bar character mapper: assertion macros
// Property wrappers for the checker file, sbcm_checker.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAR_CHAR_MAPPER_MACROS_SVH
`define SPECTRUM_BAR_CHAR_MAPPER_MACROS_SVH

// same-cycle implication, off while in reset
`define SBCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbcm assertion failed");

// fixed-delay implication, off while in reset
`define SBCM_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("sbcm assertion failed");

`endif

/* rtl/core/sbcm_pkg.sv */
// ----------------------------------------------------------------------------
// sbcm_pkg
// Widths, codes and shared types of the spectrum bar character mapper.
// ----------------------------------------------------------------------------
package sbcm_pkg;

  localparam int BIN_WIDTH = 16;
  localparam int COL_W     = 4;
  localparam int CODE_W    = 6;
  localparam int SHIFT_W   = 3;
  localparam int LEVEL_W   = 5;

  localparam logic [SHIFT_W-1:0] SHIFT_RST  = 3'd2;
  localparam logic [CODE_W-1:0]  FULL_CODE  = 6'd7;
  localparam logic [CODE_W-1:0]  BLANK_CODE = 6'd32;
  localparam logic [LEVEL_W-1:0] CELL_STEPS = 5'd8;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 5'd16;

  // component sum and its magnitude
  localparam int SUMC_W    = BIN_WIDTH + 1;
  localparam int ABS_W     = BIN_WIDTH + 1;
  localparam int CLAMP_LOG = 20;
  localparam int CMP_W     = (ABS_W > CLAMP_LOG + 1) ? CLAMP_LOG + 1 : ABS_W;
  localparam int EXT_W     = (ABS_W > CLAMP_LOG + 2) ? ABS_W : CLAMP_LOG + 2;
  localparam int SQR_W     = 2 * CMP_W;
  localparam int SUM_W     = SQR_W + 1;

  // root: even bit count, two result bits per pipeline stage
  localparam int ROOT_W    = ((SUM_W + 3) / 4) * 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQ_STAGES = ROOT_W / 2;

  // accept edge to the edge that samples the result strobe
  localparam int PIPE_LAT  = SQ_STAGES + 5;

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  column;
    logic [SUM_W-1:0]  sum;
  } fr_t;

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  column;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

endpackage

/* rtl/core/sbcm_front.sv */
// ----------------------------------------------------------------------------
// sbcm_front
// Bin add, absolute value with clamp, squares and their sum: four stages.
// ----------------------------------------------------------------------------
module sbcm_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [sbcm_pkg::COL_W-1:0]           in_column,
  input  logic signed [sbcm_pkg::BIN_WIDTH-1:0] in_first_real,
  input  logic signed [sbcm_pkg::BIN_WIDTH-1:0] in_first_imag,
  input  logic signed [sbcm_pkg::BIN_WIDTH-1:0] in_second_real,
  input  logic signed [sbcm_pkg::BIN_WIDTH-1:0] in_second_imag,
  output sbcm_pkg::fr_t                        fr_out
);

  localparam logic [sbcm_pkg::EXT_W-1:0] CLAMP_EXT =
    sbcm_pkg::EXT_W'(1) << sbcm_pkg::CLAMP_LOG;

  function automatic logic [sbcm_pkg::CMP_W-1:0] clamp_abs(
    input logic signed [sbcm_pkg::SUMC_W-1:0] x
  );
    logic signed [sbcm_pkg::SUMC_W-1:0] neg;
    logic [sbcm_pkg::ABS_W-1:0]         mag;
    neg = -x;
    mag = x[sbcm_pkg::SUMC_W-1] ? sbcm_pkg::ABS_W'(unsigned'(neg))
                                : sbcm_pkg::ABS_W'(unsigned'(x));
    if (sbcm_pkg::EXT_W'(mag) > CLAMP_EXT) begin
      return CLAMP_EXT[sbcm_pkg::CMP_W-1:0];
    end
    return mag[sbcm_pkg::CMP_W-1:0];
  endfunction

  // stage 1: component sums
  logic                                s1_valid_r;
  logic [sbcm_pkg::COL_W-1:0]          s1_column_r;
  logic signed [sbcm_pkg::SUMC_W-1:0]  s1_re_r, s1_im_r;
  // stage 2: clamped magnitudes
  logic                                s2_valid_r;
  logic [sbcm_pkg::COL_W-1:0]          s2_column_r;
  logic [sbcm_pkg::CMP_W-1:0]          s2_ar_r, s2_ai_r;
  // stage 3: squares
  logic                                s3_valid_r;
  logic [sbcm_pkg::COL_W-1:0]          s3_column_r;
  logic [sbcm_pkg::SQR_W-1:0]          s3_sqr_r, s3_sqi_r;
  // stage 4: sum of squares
  sbcm_pkg::fr_t                       s4_r, s4_nxt;

  logic signed [sbcm_pkg::SUMC_W-1:0]  s1_re_nxt, s1_im_nxt;
  logic [sbcm_pkg::CMP_W-1:0]          s2_ar_nxt, s2_ai_nxt;
  logic [sbcm_pkg::SQR_W-1:0]          s3_sqr_nxt, s3_sqi_nxt;

  always_comb begin
    s1_re_nxt  = sbcm_pkg::SUMC_W'(in_first_real) + sbcm_pkg::SUMC_W'(in_second_real);
    s1_im_nxt  = sbcm_pkg::SUMC_W'(in_first_imag) + sbcm_pkg::SUMC_W'(in_second_imag);
    s2_ar_nxt  = clamp_abs(s1_re_r);
    s2_ai_nxt  = clamp_abs(s1_im_r);
    s3_sqr_nxt = sbcm_pkg::SQR_W'(s2_ar_r) * sbcm_pkg::SQR_W'(s2_ar_r);
    s3_sqi_nxt = sbcm_pkg::SQR_W'(s2_ai_r) * sbcm_pkg::SQR_W'(s2_ai_r);
    s4_nxt.valid  = s3_valid_r;
    s4_nxt.column = s3_column_r;
    s4_nxt.sum    = sbcm_pkg::SUM_W'(s3_sqr_r) + sbcm_pkg::SUM_W'(s3_sqi_r);
  end

  always_ff @(posedge clk) begin
    s1_column_r <= in_column;
    s1_re_r     <= s1_re_nxt;
    s1_im_r     <= s1_im_nxt;
    s2_column_r <= s1_column_r;
    s2_ar_r     <= s2_ar_nxt;
    s2_ai_r     <= s2_ai_nxt;
    s3_column_r <= s2_column_r;
    s3_sqr_r    <= s3_sqr_nxt;
    s3_sqi_r    <= s3_sqi_nxt;
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_r       <= '0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_r       <= s4_nxt;
    end
  end

  assign fr_out = s4_r;

endmodule

/* rtl/core/sbcm_sqrt.sv */
// ----------------------------------------------------------------------------
// sbcm_sqrt
// Pipelined digit-by-digit integer square root, two root bits per stage.
// ----------------------------------------------------------------------------
module sbcm_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  sbcm_pkg::fr_t fr_in,
  output sbcm_pkg::sq_t sq_out
);

  // one restoring step: bring down two radicand bits, try (root<<2)|1
  function automatic sbcm_pkg::sq_t sq_step(input sbcm_pkg::sq_t s);
    sbcm_pkg::sq_t                  o;
    logic [sbcm_pkg::REM_W+1:0]     r;
    logic [sbcm_pkg::REM_W+1:0]     t;
    o = s;
    r = {s.rem, s.rad[sbcm_pkg::RAD_W-1 -: 2]};
    t = (sbcm_pkg::REM_W + 2)'({s.root, 2'b01});
    o.rad = s.rad << 2;
    if (r >= t) begin
      o.rem  = sbcm_pkg::REM_W'(r - t);
      o.root = {s.root[sbcm_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r[sbcm_pkg::REM_W-1:0];
      o.root = {s.root[sbcm_pkg::ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  sbcm_pkg::sq_t st_r   [sbcm_pkg::SQ_STAGES];
  sbcm_pkg::sq_t st_nxt [sbcm_pkg::SQ_STAGES];
  sbcm_pkg::sq_t st_init;

  always_comb begin
    st_init.valid  = fr_in.valid;
    st_init.column = fr_in.column;
    st_init.rad    = sbcm_pkg::RAD_W'(fr_in.sum);
    st_init.rem    = '0;
    st_init.root   = '0;
    st_nxt[0] = sq_step(sq_step(st_init));
    for (int i = 1; i < sbcm_pkg::SQ_STAGES; i++) begin
      st_nxt[i] = sq_step(sq_step(st_r[i-1]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sbcm_pkg::SQ_STAGES; i++) begin
      if (!rst_n) begin
        st_r[i] <= '0;
      end else begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign sq_out = st_r[sbcm_pkg::SQ_STAGES-1];

endmodule

/* rtl/core/sbcm_cells.sv */
// ----------------------------------------------------------------------------
// sbcm_cells
// Level scaling and saturation, two-cell character codes, result register.
// ----------------------------------------------------------------------------
module sbcm_cells (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbcm_pkg::sq_t                 sq_in,
  input  logic [sbcm_pkg::SHIFT_W-1:0]  scale_shift,
  output logic                          out_strobe,
  output logic [sbcm_pkg::COL_W-1:0]    out_column_out,
  output logic [sbcm_pkg::CODE_W-1:0]   out_bottom_code,
  output logic [sbcm_pkg::CODE_W-1:0]   out_top_code
);

  function automatic logic [sbcm_pkg::CODE_W-1:0] cell_code(
    input logic [sbcm_pkg::LEVEL_W-1:0] left
  );
    if (left >= sbcm_pkg::CELL_STEPS) begin
      return sbcm_pkg::FULL_CODE;
    end
    if (left == '0) begin
      return sbcm_pkg::BLANK_CODE;
    end
    return sbcm_pkg::CODE_W'(left - 1'b1);
  endfunction

  logic [sbcm_pkg::ROOT_W-1:0]  shifted;
  logic [sbcm_pkg::LEVEL_W-1:0] level, upper;

  logic                         strobe_r;
  logic [sbcm_pkg::COL_W-1:0]   column_r;
  logic [sbcm_pkg::CODE_W-1:0]  bottom_r, bottom_nxt;
  logic [sbcm_pkg::CODE_W-1:0]  top_r, top_nxt;

  always_comb begin
    shifted = sq_in.root >> scale_shift;
    if (shifted > sbcm_pkg::ROOT_W'(sbcm_pkg::LEVEL_MAX)) begin
      level = sbcm_pkg::LEVEL_MAX;
    end else begin
      level = shifted[sbcm_pkg::LEVEL_W-1:0];
    end
    // bottom cell takes up to one full cell, top gets the rest
    upper      = (level >= sbcm_pkg::CELL_STEPS) ? level - sbcm_pkg::CELL_STEPS : '0;
    bottom_nxt = cell_code(level);
    top_nxt    = cell_code(upper);
  end

  always_ff @(posedge clk) begin
    column_r <= sq_in.column;
    bottom_r <= bottom_nxt;
    top_r    <= top_nxt;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= sq_in.valid;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_column_out  = column_r;
  assign out_bottom_code = bottom_r;
  assign out_top_code    = top_r;

endmodule

/* rtl/core/spectrum_bar_char_mapper.sv */
// ----------------------------------------------------------------------------
// spectrum_bar_char_mapper
// Magnitude of two summed FFT bins mapped onto two stacked bar characters.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in_       in         start & !busy          column, two complex bins
//  out_      out        out_strobe (1 cycle)   column_out, bottom_code, top_code
//  cfg_      in         cfg_valid & cfg_ready  cfg_data = scale_shift
//
//  One request per clock while busy is low, sustained. The accept edge is followed by
//  the front stages, the square-root stages and the result register; depth is set by the
//  square-root pipeline, two root bits per stage.
//  Synchronous reset clears valid bits and sets scale_shift to 2; busy is registered,
//  set during reset and cleared once rst_n is high. The result side has no backpressure,
//  so the pipeline never stalls.
// ----------------------------------------------------------------------------
module spectrum_bar_char_mapper (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [sbcm_pkg::COL_W-1:0]            in_column,
  input  logic signed [sbcm_pkg::BIN_WIDTH-1:0] in_first_real,
  input  logic signed [sbcm_pkg::BIN_WIDTH-1:0] in_first_imag,
  input  logic signed [sbcm_pkg::BIN_WIDTH-1:0] in_second_real,
  input  logic signed [sbcm_pkg::BIN_WIDTH-1:0] in_second_imag,
  output logic                                  out_strobe,
  output logic [sbcm_pkg::COL_W-1:0]            out_column_out,
  output logic [sbcm_pkg::CODE_W-1:0]           out_bottom_code,
  output logic [sbcm_pkg::CODE_W-1:0]           out_top_code,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sbcm_pkg::SHIFT_W-1:0]          cfg_data
);

  logic                          busy_r;
  logic [sbcm_pkg::SHIFT_W-1:0]  shift_r;
  sbcm_pkg::fr_t                 fr;
  sbcm_pkg::sq_t                 sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      shift_r <= sbcm_pkg::SHIFT_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        shift_r <= cfg_data;
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;

  sbcm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (start && !busy_r),
    .in_column      (in_column),
    .in_first_real  (in_first_real),
    .in_first_imag  (in_first_imag),
    .in_second_real (in_second_real),
    .in_second_imag (in_second_imag),
    .fr_out         (fr)
  );

  sbcm_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .fr_in  (fr),
    .sq_out (sq)
  );

  sbcm_cells u_cells (
    .clk             (clk),
    .rst_n           (rst_n),
    .sq_in           (sq),
    .scale_shift     (shift_r),
    .out_strobe      (out_strobe),
    .out_column_out  (out_column_out),
    .out_bottom_code (out_bottom_code),
    .out_top_code    (out_top_code)
  );

endmodule

/* rtl/core/sbcm_checker.sv */
// ----------------------------------------------------------------------------
// sbcm_checker
// Port-level checks on the spectrum bar character mapper, bound to the top.
// ----------------------------------------------------------------------------
`include "spectrum_bar_char_mapper_macros.svh"

module sbcm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [sbcm_pkg::CODE_W-1:0]   out_bottom_code,
  input logic [sbcm_pkg::CODE_W-1:0]   out_top_code
);

  // every accepted request shows up on the result strobe
  `SBCM_ASSERT_DLY(a_req_to_result, start && !busy, sbcm_pkg::PIPE_LAT, out_strobe)

  // bottom cell is a bar code or blank
  `SBCM_ASSERT_NOW(a_bottom_code, out_strobe,
    out_bottom_code <= sbcm_pkg::FULL_CODE || out_bottom_code == sbcm_pkg::BLANK_CODE)

  // top row only lights above a full bottom cell
  `SBCM_ASSERT_NOW(a_top_needs_full, out_strobe && out_top_code != sbcm_pkg::BLANK_CODE,
    out_bottom_code == sbcm_pkg::FULL_CODE)

  // a blank bottom means an empty column
  `SBCM_ASSERT_NOW(a_blank_column, out_strobe && out_bottom_code == sbcm_pkg::BLANK_CODE,
    out_top_code == sbcm_pkg::BLANK_CODE)

endmodule

bind spectrum_bar_char_mapper sbcm_checker u_sbcm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_bottom_code (out_bottom_code),
  .out_top_code    (out_top_code)
);
